// File: sv/prht_pkg.sv
// Shared types and constants of the rolling prefix-hash table.
package prht_pkg;

  localparam int HASH_W    = 31;
  localparam int LEN_W     = 11;
  localparam int BYTE_W    = 8;
  localparam int MAX_LEN   = 1024;
  localparam int PA_W      = $clog2(MAX_LEN);
  localparam int NB_W      = $clog2(HASH_W + 1);
  localparam int CFG_IDX_W = 1;

  localparam logic [LEN_W-1:0]  MAX_LEN_L = LEN_W'(MAX_LEN);
  localparam logic [HASH_W-1:0] BASE_RST  = HASH_W'(31);
  localparam logic [HASH_W-1:0] MOD_RST   = HASH_W'(1000000007);

  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD  = 1'b1;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ORDER = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LOAD,
    S_MUL1,
    S_MUL2,
    S_FINISH
  } state_t;

endpackage

// File: sv/prefix_rolling_hash_table.sv
// Top level of the polynomial rolling prefix-hash table.
// The block holds a byte string of up to 1024 bytes together with its prefix hashes
// H(i+1) = sum c_j*base^j mod modulus and the powers base^k mod modulus. An append request
// adds one byte and returns the new prefix hash; a query request returns
// (H(end) - H(begin)) * base^(length - begin) mod modulus, or flags a range error (status 1)
// or a begin-after-end error (status 2); a clear request empties the string; an append to a
// full string is refused with status 3. One request is worked at a time. An append works
// a multiply of the byte by the stored power, a modular add, then a multiply of that
// power by the base; a query works one multiply of the difference by the power; clear,
// error and unused codes use no multiply. The block goes back to idle before the next
// request is taken. All multiplies run on the shared bit-serial modular multiplier, which
// consumes one multiplier bit per clock. Results wait in an output register, so the next
// request is accepted while the previous result is still unread. Writing either
// configuration register (only while idle) takes effect at once and also empties the
// string; a modulus of zero acts as one. No clearing pass is needed after reset: the
// length counter alone tells which table entries are live.
module prefix_rolling_hash_table import prht_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [BYTE_W-1:0]    in_byte_value,
  input  logic [LEN_W-1:0]     in_begin_index,
  input  logic [LEN_W-1:0]     in_end_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [HASH_W-1:0]    out_hash_out,
  output logic [1:0]           out_status,
  output logic [LEN_W-1:0]     out_string_length,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HASH_W-1:0]    cfg_data
);

  // control state
  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  len_r;
  logic [HASH_W-1:0] base_r;
  logic [HASH_W-1:0] mod_r;
  logic              out_valid_r;

  // request and working registers
  logic [1:0]        action_r;
  logic [BYTE_W-1:0] byte_r;
  logic [LEN_W-1:0]  begin_r;
  logic [LEN_W-1:0]  end_r;
  status_t           status_r;
  logic [HASH_W-1:0] res_r;
  logic [HASH_W-1:0] pr_r;      // stored power, reduced below the modulus
  logic [HASH_W-1:0] prev_r;    // previous prefix hash for an append
  logic              pw_zero_r; // power index zero reads as one

  // output register
  logic [HASH_W-1:0] out_hash_r;
  status_t           out_status_r;
  logic [LEN_W-1:0]  out_len_r;

  // tables: prefix hashes, and powers base^k for k = 1..MAX_LEN
  logic [HASH_W-1:0] prefix_mem [0:MAX_LEN-1];
  logic [HASH_W-1:0] pow_mem    [0:MAX_LEN];
  logic [HASH_W-1:0] pa_q, pb_q, pw_q;
  logic [PA_W-1:0]   pa_addr, pb_addr;
  logic [LEN_W-1:0]  pw_addr;

  // FSM outputs
  logic              rd_en;
  logic              pfx_we;
  logic              pow_we;
  logic              out_load;
  logic              mm_start;
  logic [HASH_W-1:0] mm_a;
  logic [HASH_W-1:0] mm_b;
  logic [NB_W-1:0]   mm_nbits;
  logic              mm_done;
  logic [HASH_W-1:0] mm_p;

  // datapath helpers
  logic              in_acc;
  logic              cfg_acc;
  logic              is_append;
  logic              is_query;
  logic              full;
  logic              range_bad;
  logic              order_bad;
  status_t           chk_status;
  logic              go_load;
  logic [HASH_W-1:0] eff_mod;
  logic [HASH_W-1:0] pw_val;
  logic [HASH_W-1:0] pw_red;
  logic [HASH_W-1:0] hs_val;
  logic [HASH_W-1:0] he_val;
  logic [HASH_W-1:0] prev_val;
  logic [HASH_W:0]   diff_wide;
  logic [HASH_W-1:0] diff;
  logic [HASH_W:0]   hsum;
  logic [HASH_W-1:0] hash_sum;

  assign in_acc  = in_valid && in_ready;
  assign cfg_acc = cfg_valid && cfg_ready;

  assign is_append = (action_r == ACT_APPEND);
  assign is_query  = (action_r == ACT_QUERY);
  assign eff_mod   = (mod_r == '0) ? HASH_W'(1) : mod_r;

  // request checks, range before order
  assign full      = (len_r >= MAX_LEN_L);
  assign range_bad = (begin_r > len_r) || (end_r > len_r);
  assign order_bad = (begin_r > end_r);

  always_comb begin
    case (action_t'(action_r))
      ACT_APPEND: chk_status = full ? ST_FULL : ST_OK;
      ACT_QUERY: begin
        if (range_bad) begin
          chk_status = ST_RANGE;
        end else if (order_bad) begin
          chk_status = ST_ORDER;
        end else begin
          chk_status = ST_OK;
        end
      end
      default: chk_status = ST_OK;
    endcase
  end

  assign go_load = (is_append && !full) || (is_query && !range_bad && !order_bad);

  // table addresses: append reads power[len] and prefix[len-1];
  // query reads power[len-begin], prefix[begin-1] and prefix[end-1]
  assign pw_addr = is_append ? len_r : (len_r - begin_r);
  assign pa_addr = is_append ? PA_W'(len_r - LEN_W'(1)) : PA_W'(begin_r - LEN_W'(1));
  assign pb_addr = PA_W'(end_r - LEN_W'(1));

  // read data: an empty prefix hashes to zero, power zero is one
  always_comb begin
    pw_val    = pw_zero_r ? HASH_W'(1) : pw_q;
    pw_red    = (pw_val >= eff_mod) ? (pw_val - eff_mod) : pw_val;
    hs_val    = (begin_r == '0) ? '0 : pa_q;
    he_val    = (end_r == '0) ? '0 : pb_q;
    prev_val  = (len_r == '0) ? '0 : pa_q;
    diff_wide = {1'b0, he_val} + {1'b0, eff_mod} - {1'b0, hs_val};
    diff      = (he_val >= hs_val) ? (he_val - hs_val) : diff_wide[HASH_W-1:0];
    hsum      = {1'b0, mm_p} + {1'b0, prev_r};
    hash_sum  = (hsum >= {1'b0, eff_mod}) ? HASH_W'(hsum - {1'b0, eff_mod})
                                          : hsum[HASH_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK:  state_nxt = go_load ? S_LOAD : S_FINISH;
      S_LOAD:   state_nxt = S_MUL1;
      S_MUL1: begin
        if (mm_done) begin
          state_nxt = is_append ? S_MUL2 : S_FINISH;
        end
      end
      S_MUL2: begin
        if (mm_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    rd_en     = 1'b0;
    pfx_we    = 1'b0;
    pow_we    = 1'b0;
    out_load  = 1'b0;
    mm_start  = 1'b0;
    mm_a      = pw_red;
    mm_b      = diff;
    mm_nbits  = NB_W'(HASH_W);
    case (state_r)
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;   // a configuration write goes first
      end
      S_CHECK: rd_en = 1'b1;
      S_LOAD: begin
        // append: byte times power; query: difference times power
        mm_start = 1'b1;
        if (is_append) begin
          mm_b     = {byte_r, {(HASH_W - BYTE_W){1'b0}}};
          mm_nbits = NB_W'(BYTE_W);
        end
      end
      S_MUL1: begin
        if (mm_done && is_append) begin
          // store the new prefix hash, then advance the power
          pfx_we   = 1'b1;
          mm_start = 1'b1;
          mm_a     = pr_r;
          mm_b     = base_r;
        end
      end
      S_MUL2:   pow_we = mm_done;
      S_FINISH: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      base_r      <= BASE_RST;
      mod_r       <= MOD_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        // either register write empties the string
        len_r <= '0;
        case (cfg_index)
          CFG_BASE: base_r <= cfg_data;
          CFG_MOD:  mod_r  <= cfg_data;
          default: ;
        endcase
      end else if (state_r == S_CHECK && action_r == ACT_CLEAR) begin
        len_r <= '0;
      end else if (pow_we) begin
        len_r <= len_r + LEN_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      action_r <= in_action;
      byte_r   <= in_byte_value;
      begin_r  <= in_begin_index;
      end_r    <= in_end_index;
    end
    if (state_r == S_CHECK) begin
      status_r  <= chk_status;
      res_r     <= '0;
      pw_zero_r <= (pw_addr == '0);
    end
    if (state_r == S_LOAD) begin
      pr_r   <= pw_red;
      prev_r <= prev_val;
    end
    if (state_r == S_MUL1 && mm_done) begin
      res_r <= is_append ? hash_sum : mm_p;
    end
    if (out_load) begin
      out_hash_r   <= res_r;
      out_status_r <= status_r;
      out_len_r    <= len_r;
    end
  end

  // prefix hash table: one write port, two read ports
  always_ff @(posedge clk) begin
    if (pfx_we) begin
      prefix_mem[len_r[PA_W-1:0]] <= hash_sum;
    end
    if (rd_en) begin
      pa_q <= prefix_mem[pa_addr];
      pb_q <= prefix_mem[pb_addr];
    end
  end

  // power table: one write port, one read port
  always_ff @(posedge clk) begin
    if (pow_we) begin
      pow_mem[len_r + LEN_W'(1)] <= mm_p;
    end
    if (rd_en) begin
      pw_q <= pow_mem[pw_addr];
    end
  end

  prht_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start),
    .a       (mm_a),
    .b       (mm_b),
    .nbits   (mm_nbits),
    .m       (eff_mod),
    .done    (mm_done),
    .product (mm_p)
  );

  assign out_valid         = out_valid_r;
  assign out_hash_out      = out_hash_r;
  assign out_status        = out_status_r;
  assign out_string_length = out_len_r;

endmodule

// File: sv/prht_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per clock, MSB first.
module prht_mulmod import prht_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [HASH_W-1:0] a,        // must already be below m
  input  logic [HASH_W-1:0] b,        // left-aligned, nbits used from the top
  input  logic [NB_W-1:0]   nbits,
  input  logic [HASH_W-1:0] m,
  output logic              done,
  output logic [HASH_W-1:0] product
);

  logic              busy_r;
  logic              done_r;
  logic [NB_W-1:0]   cnt_r;
  logic [HASH_W-1:0] a_r;
  logic [HASH_W-1:0] b_r;
  logic [HASH_W-1:0] acc_r;

  logic [HASH_W-1:0] addend;
  logic [HASH_W+1:0] sum;
  logic [HASH_W+2:0] d1;
  logic [HASH_W+2:0] d2;
  logic [HASH_W-1:0] acc_nxt;

  // acc = 2*acc + bit*a stays below 3m; remove m or 2m
  always_comb begin
    addend = b_r[HASH_W-1] ? a_r : '0;
    sum    = {1'b0, acc_r, 1'b0} + {2'b00, addend};
    d1     = {1'b0, sum} - {3'b000, m};
    d2     = {1'b0, sum} - {2'b00, m, 1'b0};
    if (!d2[HASH_W+2]) begin
      acc_nxt = d2[HASH_W-1:0];
    end else if (!d1[HASH_W+2]) begin
      acc_nxt = d1[HASH_W-1:0];
    end else begin
      acc_nxt = sum[HASH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == NB_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - NB_W'(1);
        if (cnt_r == NB_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[HASH_W-2:0], 1'b0};
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// File: sv/prht_checker.sv
// Port-level checks of the rolling prefix-hash table, bound to the top level.
module prht_checker import prht_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [HASH_W-1:0] out_hash_out,
  input logic [1:0]        out_status,
  input logic [LEN_W-1:0]  out_string_length
);

  // one request at a time: no new request right after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // a result held back stays offered with the same hash
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hash_out))
    else $error("result dropped or changed while stalled");

  // refused or failed requests return a zero hash
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_hash_out == '0))
    else $error("nonzero hash with error status");

  // the string never grows past its capacity
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_string_length <= MAX_LEN_L))
    else $error("string length beyond capacity");

endmodule

bind prefix_rolling_hash_table prht_checker u_prht_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_hash_out      (out_hash_out),
  .out_status        (out_status),
  .out_string_length (out_string_length)
);
